>>> hdl/sfe_pkg.sv
// Package for the S.BUS frame encoder: widths, frame layout constants,
// scaling constants, controller state type and framer control struct.
// No dependencies; every other file in hdl/ imports it.
package sfe_pkg;

  // Channel set and frame layout
  localparam int NUM_CHANNELS = 16;
  localparam int CH_BITS      = 11;
  localparam int CHAN_IDX_W   = 4;
  localparam int FRAME_BITS   = NUM_CHANNELS * CH_BITS;   // 176 packed bits
  localparam int DATA_BYTES   = (FRAME_BITS + 7) / 8;     // 22
  localparam int FRAME_LEN    = DATA_BYTES + 3;           // 25
  localparam int BYTE_IDX_W   = 5;

  localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(NUM_CHANNELS - 1);

  // Byte positions within a frame
  localparam logic [BYTE_IDX_W-1:0] BYTE_HDR        = BYTE_IDX_W'(0);
  localparam logic [BYTE_IDX_W-1:0] BYTE_DATA_FIRST = BYTE_IDX_W'(1);
  localparam logic [BYTE_IDX_W-1:0] BYTE_DATA_LAST  = BYTE_IDX_W'(DATA_BYTES);
  localparam logic [BYTE_IDX_W-1:0] BYTE_FLAGS      = BYTE_IDX_W'(DATA_BYTES + 1);
  localparam logic [BYTE_IDX_W-1:0] BYTE_FTR        = BYTE_IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;
  localparam int FLAG_LOSS_BIT = 2;
  localparam int FLAG_FS_BIT   = 3;

  // Stream payload layout
  localparam int IN_W       = 12;
  localparam int S_TDATA_W  = 16;
  localparam int LOSS_POS   = 12;
  localparam int FS_POS     = 13;
  localparam int M_TDATA_W  = 8;

  // Scaling: (v - 990) * 1638 / 1020 + 173 == (v - 990) * 273 / 170 + 173
  localparam logic [IN_W:0]      IN_MIN    = 13'd990;
  localparam logic [CH_BITS-1:0] OUT_MIN   = 11'd173;
  localparam int                 PROD_W    = 20;      // 3105 * 273 < 2**20
  localparam int                 REM_W     = 8;
  localparam logic [REM_W:0]     SCALE_DIV = 9'd170;
  localparam int                 DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(PROD_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // shift a new scaled channel into the frame register
    logic advance;   // current frame byte transferred
    logic loss;      // signal-loss flag for the flags byte
    logic failsafe;  // failsafe flag for the flags byte
  } frame_ctrl_t;

endpackage

>>> hdl/sfe_scaler.sv
// Channel scaler: maps a pulse width to an 11-bit S.BUS value with a
// bit-serial restoring divider (one quotient bit per cycle). Uses sfe_pkg.
module sfe_scaler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sfe_pkg::IN_W-1:0]    value,
  output logic                        done,
  output logic [sfe_pkg::CH_BITS-1:0] result
);
  import sfe_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [REM_W-1:0]     rem;
  logic [PROD_W-1:0]    dvd;   // dividend in, quotient out

  logic [IN_W:0]     diff;
  logic [IN_W:0]     diff_abs;
  logic [PROD_W-1:0] mag_ext;
  logic [PROD_W-1:0] prod;
  logic [REM_W:0]    trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [CH_BITS-1:0] q_low;
  logic [CH_BITS-1:0] q_signed;

  // Signed offset, then magnitude times 273 as shift-and-add
  assign diff     = {1'b0, value} - IN_MIN;
  assign diff_abs = diff[IN_W] ? (~diff + 1'b1) : diff;
  assign mag_ext  = PROD_W'(diff_abs[IN_W-1:0]);
  assign prod     = (mag_ext << 8) + (mag_ext << 4) + mag_ext;

  // One restoring step
  assign trial    = {rem, dvd[PROD_W-1]};
  assign ge       = (trial >= SCALE_DIV);
  assign rem_next = ge ? REM_W'(trial - SCALE_DIV) : trial[REM_W-1:0];

  // Truncation toward zero: negate the magnitude quotient; keep 11 bits
  assign q_low    = dvd[CH_BITS-1:0];
  assign q_signed = neg ? (~q_low + 1'b1) : q_low;
  assign result   = q_signed + OUT_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= diff[IN_W];
      rem <= '0;
      dvd <= prod;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[PROD_W-2:0], ge};
    end
  end

endmodule

>>> hdl/sfe_framer.sv
// Frame builder: 176-bit shift register collecting channels, emitted a
// byte per transfer between header, flags and footer. Uses sfe_pkg.
module sfe_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  sfe_pkg::frame_ctrl_t          ctrl,
  input  logic [sfe_pkg::CH_BITS-1:0]   chan_value,
  output logic [sfe_pkg::M_TDATA_W-1:0] frame_byte,
  output logic                          last_byte
);
  import sfe_pkg::*;

  logic [FRAME_BITS-1:0] sreg;
  logic [BYTE_IDX_W-1:0] byte_idx;
  logic                  is_data;
  logic [7:0]            flags;

  assign is_data   = (byte_idx >= BYTE_DATA_FIRST) && (byte_idx <= BYTE_DATA_LAST);
  assign last_byte = (byte_idx == BYTE_FTR);

  always_comb begin
    flags = '0;
    flags[FLAG_LOSS_BIT] = ctrl.loss;
    flags[FLAG_FS_BIT]   = ctrl.failsafe;
  end

  always_comb begin
    case (byte_idx)
      BYTE_HDR:   frame_byte = HDR_BYTE;
      BYTE_FLAGS: frame_byte = flags;
      BYTE_FTR:   frame_byte = FTR_BYTE;
      default:    frame_byte = sreg[7:0];
    endcase
  end

  // New channels enter at the top, so channel 0 ends up in the low bits
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sreg <= {chan_value, sreg[FRAME_BITS-1:CH_BITS]};
    end else if (ctrl.advance && is_data) begin
      sreg <= {8'h00, sreg[FRAME_BITS-1:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= BYTE_HDR;
    end else if (ctrl.advance) begin
      byte_idx <= last_byte ? BYTE_HDR : byte_idx + 1'b1;
    end
  end

endmodule

>>> hdl/sbus_frame_encoder.sv
// S.BUS 16-channel frame encoder, top level: controller, channel counter,
// scaler and framer. Uses sfe_pkg, sfe_scaler, sfe_framer.
//
// Usage:
//  - Slave stream (s_*): one transfer per channel, channel 0 first. tdata
//    carries the pulse width in microseconds plus the two status flags;
//    the flags only matter on the sixteenth transfer of a frame.
//  - Master stream (m_*): after the sixteenth channel, 25 byte transfers:
//    header 0x0F, 22 packed channel bytes (LSB first), flags byte, footer
//    0x00 with tlast set.
//  - Each channel passes through the accept cycle, the bit-serial divider
//    in the scaler, and a shift of the scaled value into the frame
//    register. s_tready is low from after the accept until that shift.
//  - After the sixteenth channel s_tready stays low until the footer
//    transfer.
//  - A stall on the master side simply holds the current byte; nothing
//    is lost, and input stays blocked until the frame is out.
//  - Reset (rst, synchronous) returns to channel 0 with no frame pending;
//    stored channel values are not cleared, since every one is rewritten
//    before the next frame goes out.
module sbus_frame_encoder (
  input  logic                          clk,
  input  logic                          rst,
  // tdata: [11:0] channel_value, [12] signal_loss, [13] failsafe, [15:14] zero
  input  logic [sfe_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: [7:0] frame_byte
  output logic [sfe_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tlast
);
  import sfe_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CHAN_IDX_W-1:0] chan_count;
  logic                  loss_q;
  logic                  fs_q;

  logic                  in_xfer;
  logic                  scale_done;
  logic [CH_BITS-1:0]    scale_result;
  frame_ctrl_t           fctrl;

  assign in_xfer = s_tvalid && s_tready;

  sfe_scaler u_scaler (
    .clk    (clk),
    .rst    (rst),
    .start  (in_xfer),
    .value  (s_tdata[IN_W-1:0]),
    .done   (scale_done),
    .result (scale_result)
  );

  sfe_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fctrl),
    .chan_value (scale_result),
    .frame_byte (m_tdata),
    .last_byte  (m_tlast)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_SCALE;
      end
      S_SCALE: begin
        if (scale_done) state_next = (chan_count == LAST_CHAN) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (m_tready && m_tlast) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    fctrl.load     = 1'b0;
    fctrl.advance  = 1'b0;
    fctrl.loss     = loss_q;
    fctrl.failsafe = fs_q;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_SCALE: fctrl.load = scale_done;
      S_EMIT: begin
        m_tvalid      = 1'b1;
        fctrl.advance = m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chan_count <= '0;
    end else begin
      state <= state_next;
      if (fctrl.load) chan_count <= chan_count + 1'b1;  // wraps after channel 15
    end
  end

  // Flags from the most recent transfer; the sixteenth one is in place
  // for the whole frame since input is blocked until the footer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      loss_q <= s_tdata[LOSS_POS];
      fs_q   <= s_tdata[FS_POS];
    end
  end

endmodule

>>> hdl/sfe_checker.sv
// Port-level checker for sbus_frame_encoder, bound to the top level.
// Uses sfe_pkg for payload widths.
module sfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [sfe_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic                          m_tlast
);
  import sfe_pkg::*;

  // Stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output byte changed while stalled");

  // Input is blocked while a frame is going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during frame output");

  // Scaler is busy right after a channel transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready again right after a channel transfer");

  // Footer byte is zero
  a_footer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == FTR_BYTE))
    else $error("footer byte not zero");

  // Frame ends and output goes idle after the footer transfer
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output still valid after footer");

endmodule

bind sbus_frame_encoder sfe_checker u_sfe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast)
);
